// ----- rtl/core/udpsd_pkg.sv -----
// types and constants shared by the udp socket bind and demux table
`timescale 1ns / 1ps

package udpsd_pkg;

   localparam int IP_W    = 32;
   localparam int PORT_W  = 16;
   localparam int STAT_W  = 3;
   localparam int SLOT_W  = 4;

   localparam logic MODE_BIND    = 1'b0;
   localparam logic MODE_DELIVER = 1'b1;

   localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_IN_USE   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NO_PORT  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NO_MATCH = 3'd4;

   localparam logic [PORT_W-1:0] PORT_ANY        = 16'd0;
   localparam logic [PORT_W-1:0] FIRST_EPHEMERAL = 16'd1024;
   localparam logic [PORT_W-1:0] LAST_EPHEMERAL  = 16'd65534;
   localparam logic [IP_W-1:0]   IP_ANY          = 32'd0;

   typedef struct packed {
      logic              mode;
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
   } tok_type;

   typedef struct packed {
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
   } entry_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [SLOT_W-1:0] slot;
      logic [PORT_W-1:0] bound_port;
      logic              last;
   } rsp_type;

endpackage

// ----- rtl/core/udpsd_cell.sv -----
// one table cell: holds an entry, compares the passing query and hands it on
`timescale 1ns / 1ps

module udpsd_cell (
   input  logic                clock,
   input  logic                wr_en,
   input  udpsd_pkg::entry_type wr_data,
   input  udpsd_pkg::tok_type   tok_left,
   output udpsd_pkg::tok_type   tok_right,
   output logic                hit
);
   import udpsd_pkg::*;

   tok_type   tok_ff;
   entry_type entry_ff;
   logic      ip_ok;

   always_ff @(posedge clock) begin
      tok_ff <= tok_left;
      if (wr_en) begin
         entry_ff <= wr_data;
      end
   end

   // wildcard on the query side only counts for a bind
   assign ip_ok = (entry_ff.ip == IP_ANY) || (entry_ff.ip == tok_ff.ip) ||
                  ((tok_ff.mode == MODE_BIND) && (tok_ff.ip == IP_ANY));

   assign hit       = (entry_ff.port == tok_ff.port) && ip_ok;
   assign tok_right = tok_ff;

endmodule

// ----- rtl/core/udpsd_ctrl.sv -----
// sequencer: feeds queries into the cell chain, allocates ports, writes entries, emits results
`timescale 1ns / 1ps

module udpsd_ctrl #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_mode,
   input  logic [udpsd_pkg::IP_W-1:0]     req_ip_address,
   input  logic [udpsd_pkg::PORT_W-1:0]   req_port,
   output udpsd_pkg::tok_type             tok_out,
   input  logic [TABLE_DEPTH-1:0]         hit_vec,
   output logic [TABLE_DEPTH-1:0]         wr_en,
   output udpsd_pkg::entry_type           wr_data,
   output logic                           rsp_strobe,
   output udpsd_pkg::rsp_type             rsp
);
   import udpsd_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = IDX_W + 1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_LOAD  = 4'b0010,
      S_SCAN  = 4'b0100,
      S_FINAL = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic              q_mode_ff, q_mode_in;
   logic [IP_W-1:0]   q_ip_ff, q_ip_in;
   logic [PORT_W-1:0] q_port_ff, q_port_in;
   logic              alloc_ff, alloc_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_slot_ff, pend_slot_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic              hit;
   logic              scan_end;
   logic              full;
   logic              do_write;
   logic [IDX_W+SLOT_W-1:0] pend_slot_ext;
   logic [IDX_W+SLOT_W-1:0] count_slot_ext;

   assign hit           = hit_vec[scan_idx_ff];
   assign scan_end      = (({1'b0, scan_idx_ff} + CNT_W'(1)) == count_ff);
   assign full          = (count_ff == CNT_W'(TABLE_DEPTH));
   assign pend_slot_ext = {{SLOT_W{1'b0}}, pend_slot_ff};
   assign count_slot_ext = {{SLOT_W{1'b0}}, count_ff[IDX_W-1:0]};
   assign do_write      = (state_ff == S_FINAL) && (q_mode_ff == MODE_BIND) && !full;

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         wr_en[i] = do_write && (count_ff[IDX_W-1:0] == IDX_W'(i));
      end
   end

   assign wr_data.ip   = q_ip_ff;
   assign wr_data.port = q_port_ff;

   assign tok_out.mode = q_mode_ff;
   assign tok_out.ip   = q_ip_ff;
   assign tok_out.port = q_port_ff;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      q_mode_in     = q_mode_ff;
      q_ip_in       = q_ip_ff;
      q_port_in     = q_port_ff;
      alloc_in      = alloc_ff;
      scan_idx_in   = scan_idx_ff;
      count_in      = count_ff;
      pend_in       = pend_ff;
      pend_slot_in  = pend_slot_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               q_mode_in = req_mode;
               q_ip_in   = req_ip_address;
               alloc_in  = (req_mode == MODE_BIND) && (req_port == PORT_ANY);
               q_port_in = ((req_mode == MODE_BIND) && (req_port == PORT_ANY)) ?
                           FIRST_EPHEMERAL : req_port;
               pend_in   = 1'b0;
               state_in  = S_LOAD;
            end
         end
         S_LOAD: begin
            scan_idx_in = '0;
            state_in    = (count_ff == '0) ? S_FINAL : S_SCAN;
         end
         S_SCAN: begin
            if (q_mode_ff == MODE_BIND) begin
               if (hit) begin
                  if (alloc_ff && (q_port_ff != LAST_EPHEMERAL)) begin
                     q_port_in = q_port_ff + PORT_W'(1);
                     state_in  = S_LOAD;
                  end else begin
                     rsp_strobe_in     = 1'b1;
                     rsp_in.status     = alloc_ff ? STAT_NO_PORT : STAT_IN_USE;
                     rsp_in.slot       = '0;
                     rsp_in.bound_port = '0;
                     rsp_in.last       = 1'b1;
                     state_in          = S_IDLE;
                  end
               end else if (scan_end) begin
                  state_in = S_FINAL;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end else begin
               if (hit) begin
                  if (pend_ff) begin
                     rsp_strobe_in     = 1'b1;
                     rsp_in.status     = STAT_OK;
                     rsp_in.slot       = pend_slot_ext[SLOT_W-1:0];
                     rsp_in.bound_port = '0;
                     rsp_in.last       = 1'b0;
                  end
                  pend_in      = 1'b1;
                  pend_slot_in = scan_idx_ff;
               end
               if (scan_end) begin
                  state_in = S_FINAL;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end
         end
         S_FINAL: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.last       = 1'b1;
            rsp_in.bound_port = '0;
            rsp_in.slot       = '0;
            if (q_mode_ff == MODE_BIND) begin
               if (full) begin
                  rsp_in.status = STAT_FULL;
               end else begin
                  rsp_in.status     = STAT_OK;
                  rsp_in.slot       = count_slot_ext[SLOT_W-1:0];
                  rsp_in.bound_port = q_port_ff;
                  count_in          = count_ff + CNT_W'(1);
               end
            end else if (pend_ff) begin
               rsp_in.status = STAT_OK;
               rsp_in.slot   = pend_slot_ext[SLOT_W-1:0];
            end else begin
               rsp_in.status = STAT_NO_MATCH;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      q_mode_ff    <= q_mode_in;
      q_ip_ff      <= q_ip_in;
      q_port_ff    <= q_port_in;
      alloc_ff     <= alloc_in;
      scan_idx_ff  <= scan_idx_in;
      pend_ff      <= pend_in;
      pend_slot_ff <= pend_slot_in;
      rsp_ff       <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_single_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wr_en))
      else $error("more than one cell written at once");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_write_gives_ok: assert property (@(posedge clock) disable iff (reset)
      (wr_en != '0) |=> (rsp_strobe && rsp.status == STAT_OK && rsp.last))
      else $error("entry written without a successful bind result");

   a_quiet_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp.last) |=> !rsp_strobe)
      else $error("result after the final transfer of an item");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");
`endif

endmodule

// ----- rtl/core/udp_socket_bind_and_demux_table_top.sv -----
// Bind/demux table for udp sockets. An item is accepted when start is high and busy is
// low. Each item runs passes through a chain of TABLE_DEPTH cells, one cell per cycle.
// A deliver keeps busy high while it scans all n bound entries, and so does a bind that
// succeeds or finds the table full; a bind refused on a clash at entry k stops there.
// A bind on port 0 first runs one extra pass for each candidate port found taken, each
// pass ending its scan at the clashing entry k; at most n candidates can be taken.
// Results come at most one per cycle on rsp_strobe, the last marked by rsp_last; the final
// one is on the ports in the first cycle with busy low, and the receiver cannot stall them.
`timescale 1ns / 1ps

module udp_socket_bind_and_demux_table_top #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_mode,
   input  logic [udpsd_pkg::IP_W-1:0]   req_ip_address,
   input  logic [udpsd_pkg::PORT_W-1:0] req_port,
   output logic                         rsp_strobe,
   output logic [udpsd_pkg::STAT_W-1:0] rsp_status,
   output logic [udpsd_pkg::SLOT_W-1:0] rsp_slot,
   output logic [udpsd_pkg::PORT_W-1:0] rsp_bound_port,
   output logic                         rsp_last
);
   import udpsd_pkg::*;

   tok_type                tok_chain [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0] hit_vec;
   logic [TABLE_DEPTH-1:0] wr_en;
   entry_type              wr_data;
   rsp_type                rsp;

   udpsd_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_ip_address (req_ip_address),
      .req_port       (req_port),
      .tok_out        (tok_chain[0]),
      .hit_vec        (hit_vec),
      .wr_en          (wr_en),
      .wr_data        (wr_data),
      .rsp_strobe     (rsp_strobe),
      .rsp            (rsp)
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      udpsd_cell u_cell (
         .clock     (clock),
         .wr_en     (wr_en[i]),
         .wr_data   (wr_data),
         .tok_left  (tok_chain[i]),
         .tok_right (tok_chain[i+1]),
         .hit       (hit_vec[i])
      );
   end

   // tail of the chain
   logic tail_unused;
   assign tail_unused = ^tok_chain[TABLE_DEPTH];

   assign rsp_status     = rsp.status;
   assign rsp_slot       = rsp.slot;
   assign rsp_bound_port = rsp.bound_port;
   assign rsp_last       = rsp.last;

endmodule

// ----- dv/udp_socket_bind_and_demux_table_top_tb.sv -----
// self-checking testbench for the udp socket bind and demux table
`timescale 1ns / 1ps

module udp_socket_bind_and_demux_table_top_tb;
   import udpsd_pkg::*;

   localparam int TABLE_DEPTH   = 16;
   localparam int RANDOM_ITEMS  = 200;
   localparam int TAIL_CYCLES   = 20;
   localparam int STALL_LIMIT   = 5000;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_mode = MODE_BIND;
   logic [IP_W-1:0]     req_ip_address = IP_ANY;
   logic [PORT_W-1:0]   req_port = PORT_ANY;
   logic                rsp_strobe;
   logic [STAT_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [PORT_W-1:0]   rsp_bound_port;
   logic                rsp_last;

   tok_type   queued_requests[$];
   rsp_type   results_due[$];
   entry_type tried_binds[$];

   logic [IP_W-1:0]   sock_ip[TABLE_DEPTH];
   logic [PORT_W-1:0] sock_port[TABLE_DEPTH];
   int                sock_count = 0;

   int outcome_tally[8];
   int bind_count = 0;
   int lookup_count = 0;
   int results_checked = 0;
   int fail_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_cycles = 0;

   udp_socket_bind_and_demux_table_top #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_ip_address(req_ip_address),
      .req_port(req_port),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_slot(rsp_slot),
      .rsp_bound_port(rsp_bound_port),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit port_clash(logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
      for (int i = 0; i < sock_count; i++) begin
         if (sock_port[i] == port &&
             (sock_ip[i] == IP_ANY || ip == IP_ANY || sock_ip[i] == ip))
            return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic resolve_socket_op(logic mode, logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
      rsp_type           r;
      int                cand;
      int                hits;
      int                k;
      logic [PORT_W-1:0] bind_port;
      r = '0;
      bind_port = port;
      if (mode == MODE_BIND) begin
         bind_count++;
         r.last = 1'b1;
         r.status = STAT_OK;
         if (port == PORT_ANY) begin
            cand = int'(FIRST_EPHEMERAL);
            while (cand <= int'(LAST_EPHEMERAL) && port_clash(ip, cand[PORT_W-1:0]))
               cand++;
            if (cand > int'(LAST_EPHEMERAL))
               r.status = STAT_NO_PORT;
            else
               bind_port = cand[PORT_W-1:0];
         end
         if (r.status == STAT_OK) begin
            if (port_clash(ip, bind_port)) begin
               r.status = STAT_IN_USE;
            end else if (sock_count >= TABLE_DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               sock_ip[sock_count] = ip;
               sock_port[sock_count] = bind_port;
               r.slot = sock_count[SLOT_W-1:0];
               r.bound_port = bind_port;
               sock_count++;
            end
         end
         outcome_tally[r.status]++;
         results_due.push_back(r);
      end else begin
         lookup_count++;
         hits = 0;
         for (int i = 0; i < sock_count; i++) begin
            if (sock_port[i] == port && (sock_ip[i] == IP_ANY || sock_ip[i] == ip))
               hits++;
         end
         if (hits == 0) begin
            r.status = STAT_NO_MATCH;
            r.last = 1'b1;
            outcome_tally[STAT_NO_MATCH]++;
            results_due.push_back(r);
         end else begin
            k = 0;
            for (int i = 0; i < sock_count; i++) begin
               if (sock_port[i] == port && (sock_ip[i] == IP_ANY || sock_ip[i] == ip)) begin
                  k++;
                  r.status = STAT_OK;
                  r.slot = i[SLOT_W-1:0];
                  r.bound_port = PORT_ANY;
                  r.last = (k == hits);
                  results_due.push_back(r);
               end
            end
         end
      end
   endtask

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic add_req(logic mode, logic [IP_W-1:0] ip, logic [PORT_W-1:0] port);
      tok_type t;
      t.mode = mode;
      t.ip = ip;
      t.port = port;
      queued_requests.push_back(t);
      if (mode == MODE_BIND) begin
         tried_binds.push_back('{ip: ip, port: port});
      end
   endtask

   function automatic logic [IP_W-1:0] pick_ip();
      case ($urandom_range(5))
         0: return IP_ANY;
         1: return '1;
         2, 3: return 32'h0a00_0000 | $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [PORT_W-1:0] pick_port();
      case ($urandom_range(5))
         0: return PORT_ANY;
         1: return '1;
         2, 3: return FIRST_EPHEMERAL + PORT_W'($urandom_range(3));
         default: return PORT_W'($urandom_range(65535));
      endcase
   endfunction

   // request driver: bursts of transfers with random gaps
   always @(posedge clock) begin
      tok_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            resolve_socket_op(req_mode, req_ip_address, req_port);
         end
         if (!start || !busy) begin
            if (gap_left > 0 || queued_requests.size() == 0) begin
               if (gap_left > 0) gap_left--;
               start <= 1'b0;
            end else begin
               nxt = queued_requests.pop_front();
               req_mode <= nxt.mode;
               req_ip_address <= nxt.ip;
               req_port <= nxt.port;
               start <= 1'b1;
               if (burst_left == 0) burst_left = $urandom_range(1, 12);
               burst_left--;
               if (burst_left == 0)
                  gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (results_due.size() == 0) begin
            $error("result with nothing expected: status %0d slot %0d", rsp_status, rsp_slot);
            fail_count++;
         end else begin
            want = results_due.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("slot", want.slot, rsp_slot);
            check_field("bound_port", want.bound_port, rsp_bound_port);
            check_field("last", want.last, rsp_last);
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL udp_socket_bind_and_demux_table_top");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      entry_type known;
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
      int roll;

      // directed: allocation, wildcard clashes on both sides, extremes, misses
      add_req(MODE_DELIVER, IP_ANY, PORT_ANY);
      add_req(MODE_BIND, 32'h0a00_0001, FIRST_EPHEMERAL);
      add_req(MODE_BIND, IP_ANY, PORT_ANY);
      add_req(MODE_BIND, 32'h0a00_0002, PORT_ANY);
      add_req(MODE_BIND, 32'h0a00_0001, FIRST_EPHEMERAL);
      add_req(MODE_BIND, IP_ANY, FIRST_EPHEMERAL);
      add_req(MODE_BIND, 32'h0a00_0009, FIRST_EPHEMERAL + 16'd1);
      add_req(MODE_BIND, '1, '1);
      add_req(MODE_BIND, IP_ANY, PORT_ANY);
      add_req(MODE_DELIVER, 32'h0a00_0001, FIRST_EPHEMERAL);
      add_req(MODE_DELIVER, 32'h0a00_0002, FIRST_EPHEMERAL);
      add_req(MODE_DELIVER, 32'h0102_0304, FIRST_EPHEMERAL + 16'd1);
      add_req(MODE_DELIVER, '1, '1);
      add_req(MODE_DELIVER, '1, LAST_EPHEMERAL);
      add_req(MODE_DELIVER, IP_ANY, FIRST_EPHEMERAL);
      add_req(MODE_DELIVER, IP_ANY, FIRST_EPHEMERAL + 16'd1);
      add_req(MODE_BIND, IP_ANY, '1);
      add_req(MODE_BIND, 32'h0505_0505, PORT_ANY);
      add_req(MODE_DELIVER, 32'h0505_0505, FIRST_EPHEMERAL);
      add_req(MODE_BIND, 32'h0a00_0003, LAST_EPHEMERAL);
      add_req(MODE_DELIVER, 32'h0a00_0003, LAST_EPHEMERAL);

      // random: binds mostly on a narrow address and port set so clashes and a full table occur, mixed with delivers
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(99);
         if (roll < 30) begin
            add_req(MODE_BIND, pick_ip(), pick_port());
         end else if (roll < 80) begin
            known = tried_binds[$urandom_range(tried_binds.size() - 1)];
            ip = (known.ip == IP_ANY && $urandom_range(1)) ? pick_ip() : known.ip;
            port = (known.port == PORT_ANY) ? FIRST_EPHEMERAL + PORT_W'($urandom_range(3))
                                            : known.port;
            add_req(MODE_DELIVER, ip, port);
         end else begin
            add_req(MODE_DELIVER, pick_ip(), pick_port());
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (queued_requests.size() != 0 || start || results_due.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d binds and %0d lookups, %0d results checked, %0d entries bound",
               bind_count, lookup_count, results_checked, sock_count);
      $display("refused binds: %0d in use, %0d table full; lookups with no match: %0d",
               outcome_tally[STAT_IN_USE], outcome_tally[STAT_FULL],
               outcome_tally[STAT_NO_MATCH]);
      if (fail_count == 0) begin
         $display("PASS udp_socket_bind_and_demux_table_top");
      end else begin
         $display("FAIL udp_socket_bind_and_demux_table_top");
      end
      $finish;
   end

endmodule
